@@ rtl/oat_pkg.sv @@
// ----------------------------------------------------------------------------
// oat_pkg
// Shared types and constants for the ordered array table: field widths,
// request and status codes, and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package oat_pkg;

  localparam int DEPTH_DEFAULT = 256;

  localparam int OP_W   = 3;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 9;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 9;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_DEL_ORDER  = 3'd1,
    OP_DEL_SWAP   = 3'd2,
    OP_LINEAR     = 3'd3,
    OP_BIN_EXACT  = 3'd4,
    OP_LOWER      = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  // what a cell does with its stored entry
  typedef enum logic [1:0] {
    EO_HOLD,
    EO_INSERT,
    EO_DELETE,
    EO_WRITE
  } entry_op_t;

  // what a cell does with its readout ring stage
  typedef enum logic [1:0] {
    RO_HOLD,
    RO_LOAD,
    RO_LEFT,
    RO_RIGHT
  } ring_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SWAP,
    S_BSEARCH,
    S_FLUSH
  } state_t;

  typedef struct packed {
    entry_op_t               entry_op;
    ring_op_t                ring_op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] data;
  } cell_ctrl_t;

endpackage

@@ rtl/oat_if.sv @@
// ----------------------------------------------------------------------------
// oat_if
// Valid/ready channels of the ordered array table: request and response.
// ----------------------------------------------------------------------------
interface oat_req_if;
  logic                              valid;
  logic                              ready;
  logic [oat_pkg::OP_W-1:0]          operation;
  logic [oat_pkg::POS_W-1:0]         position;
  logic signed [oat_pkg::VAL_W-1:0]  value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

interface oat_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [oat_pkg::IDX_W-1:0]   index;
  logic                        found;
  logic [oat_pkg::STAT_W-1:0]  status;
  logic [oat_pkg::CNT_W-1:0]   entry_count;

  modport source (output valid, index, found, status, entry_count, input ready);
  modport sink   (input valid, index, found, status, entry_count, output ready);
endinterface

@@ rtl/oat_cell.sv @@
// ----------------------------------------------------------------------------
// oat_cell
// One table cell: a stored entry that shifts with its neighbours on insert
// and ordered delete, and one stage of the rotating readout ring.
// ----------------------------------------------------------------------------
module oat_cell #(
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  oat_pkg::cell_ctrl_t              ctrl,
  input  logic signed [oat_pkg::VAL_W-1:0] left_entry,
  input  logic signed [oat_pkg::VAL_W-1:0] right_entry,
  input  logic signed [oat_pkg::VAL_W-1:0] ring_left,
  input  logic signed [oat_pkg::VAL_W-1:0] ring_right,
  output logic signed [oat_pkg::VAL_W-1:0] entry,
  output logic signed [oat_pkg::VAL_W-1:0] ring
);

  localparam logic [31:0] MY_IDX = 32'(IDX);

  logic [31:0]                      pos_x;
  logic signed [oat_pkg::VAL_W-1:0] entry_next;
  logic signed [oat_pkg::VAL_W-1:0] ring_next;

  assign pos_x = 32'(ctrl.pos);

  always_comb begin
    unique case (ctrl.entry_op)
      oat_pkg::EO_INSERT: begin
        if (MY_IDX > pos_x) begin
          entry_next = left_entry;
        end else if (MY_IDX == pos_x) begin
          entry_next = ctrl.data;
        end else begin
          entry_next = entry;
        end
      end
      oat_pkg::EO_DELETE: entry_next = (MY_IDX >= pos_x) ? right_entry : entry;
      oat_pkg::EO_WRITE:  entry_next = (MY_IDX == pos_x) ? ctrl.data : entry;
      default:            entry_next = entry;
    endcase
  end

  always_comb begin
    unique case (ctrl.ring_op)
      oat_pkg::RO_LOAD:  ring_next = entry;
      oat_pkg::RO_LEFT:  ring_next = ring_right;
      oat_pkg::RO_RIGHT: ring_next = ring_left;
      default:           ring_next = ring;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    ring  <= ring_next;
  end

endmodule

@@ rtl/oat_seq.sv @@
// ----------------------------------------------------------------------------
// oat_seq
// Request sequencer: decodes requests, steers the cell row, walks the
// readout ring for searches and swap-last, and holds the response register.
// ----------------------------------------------------------------------------
module oat_seq #(
  parameter int DEPTH = oat_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  oat_req_if.sink                          req,
  oat_rsp_if.source                        rsp,
  input  logic signed [oat_pkg::VAL_W-1:0] head,
  output oat_pkg::cell_ctrl_t              ctrl
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int XW = (CW > oat_pkg::POS_W) ? CW : oat_pkg::POS_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  oat_pkg::state_t state, state_next;

  logic [CW-1:0] n, n_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hx, hx_next;

  oat_pkg::op_t                     op_q, op_in;
  logic [oat_pkg::POS_W-1:0]        pos_q;
  logic signed [oat_pkg::VAL_W-1:0] key_q;

  logic [oat_pkg::IDX_W-1:0] res_index, res_index_next;
  logic                      res_found, res_found_next;
  oat_pkg::status_t          res_status, res_status_next;
  logic [oat_pkg::CNT_W-1:0] res_count, res_count_next;

  logic                      out_valid;
  logic [oat_pkg::IDX_W-1:0] out_index;
  logic                      out_found;
  oat_pkg::status_t          out_status;
  logic [oat_pkg::CNT_W-1:0] out_count;

  logic          accept, out_free, out_load;
  logic          full, ins_range, del_range;
  logic          exact, head_eq, head_lt;
  logic [SW-1:0] mid_sum;
  logic [CW-1:0] mid;
  logic          at_mid, scan_done, swap_done, bs_empty, bs_done;

  assign op_in     = oat_pkg::op_t'(req.operation);
  assign req.ready = (state == oat_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;

  assign out_free = !out_valid || rsp.ready;
  assign out_load = (state == oat_pkg::S_FLUSH) && out_free;

  assign full      = (n == DEPTH_C);
  assign ins_range = XW'(req.position) >  XW'(n);
  assign del_range = XW'(req.position) >= XW'(n);

  assign exact   = (op_q == oat_pkg::OP_BIN_EXACT);
  assign head_eq = (head == key_q);
  assign head_lt = (head < key_q);

  // exact search keeps hx = hi + 1, so its midpoint drops one
  assign mid_sum = SW'(lo) + SW'(hx) - SW'(exact);
  assign mid     = mid_sum[CW:1];
  assign at_mid  = (ptr == mid);

  assign scan_done = (ptr == n) || head_eq;
  assign swap_done = (ptr == n - ONE_C);
  assign bs_empty  = (lo >= hx);
  assign bs_done   = bs_empty || (at_mid && head_eq && exact);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      oat_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op_in)
            oat_pkg::OP_DEL_SWAP: begin
              state_next = del_range ? oat_pkg::S_FLUSH : oat_pkg::S_SWAP;
            end
            oat_pkg::OP_LINEAR:    state_next = oat_pkg::S_SCAN;
            oat_pkg::OP_BIN_EXACT: state_next = oat_pkg::S_BSEARCH;
            oat_pkg::OP_LOWER:     state_next = oat_pkg::S_BSEARCH;
            default:               state_next = oat_pkg::S_FLUSH;
          endcase
        end
      end
      oat_pkg::S_SCAN:    if (scan_done) state_next = oat_pkg::S_FLUSH;
      oat_pkg::S_SWAP:    if (swap_done) state_next = oat_pkg::S_FLUSH;
      oat_pkg::S_BSEARCH: if (bs_done)   state_next = oat_pkg::S_FLUSH;
      oat_pkg::S_FLUSH:   if (out_free)  state_next = oat_pkg::S_IDLE;
      default:            state_next = oat_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    ctrl            = '{oat_pkg::EO_HOLD, oat_pkg::RO_HOLD, pos_q, key_q};
    n_next          = n;
    ptr_next        = ptr;
    lo_next         = lo;
    hx_next         = hx;
    res_index_next  = res_index;
    res_found_next  = res_found;
    res_status_next = res_status;
    res_count_next  = res_count;

    unique case (state)
      oat_pkg::S_IDLE: begin
        if (accept) begin
          ctrl.pos        = req.position;
          ctrl.data       = req.value;
          ptr_next        = '0;
          lo_next         = '0;
          hx_next         = n;
          res_index_next  = '0;
          res_found_next  = 1'b0;
          res_status_next = oat_pkg::STAT_OK;
          res_count_next  = oat_pkg::CNT_W'(n);
          unique case (op_in)
            oat_pkg::OP_INSERT: begin
              res_index_next = oat_pkg::IDX_W'(req.position);
              if (full) begin
                res_status_next = oat_pkg::STAT_FULL;
              end else if (ins_range) begin
                res_status_next = oat_pkg::STAT_RANGE;
              end else begin
                ctrl.entry_op  = oat_pkg::EO_INSERT;
                n_next         = n + ONE_C;
                res_count_next = oat_pkg::CNT_W'(n + ONE_C);
              end
            end
            oat_pkg::OP_DEL_ORDER: begin
              res_index_next = oat_pkg::IDX_W'(req.position);
              if (del_range) begin
                res_status_next = oat_pkg::STAT_RANGE;
              end else begin
                ctrl.entry_op  = oat_pkg::EO_DELETE;
                n_next         = n - ONE_C;
                res_count_next = oat_pkg::CNT_W'(n - ONE_C);
              end
            end
            oat_pkg::OP_DEL_SWAP: begin
              res_index_next = oat_pkg::IDX_W'(req.position);
              if (del_range) begin
                res_status_next = oat_pkg::STAT_RANGE;
              end else begin
                ctrl.ring_op = oat_pkg::RO_LOAD;
              end
            end
            oat_pkg::OP_LINEAR:    ctrl.ring_op = oat_pkg::RO_LOAD;
            oat_pkg::OP_BIN_EXACT: ctrl.ring_op = oat_pkg::RO_LOAD;
            oat_pkg::OP_LOWER:     ctrl.ring_op = oat_pkg::RO_LOAD;
            default: ;
          endcase
        end
      end
      oat_pkg::S_SCAN: begin
        if (ptr == n) begin
          res_index_next = oat_pkg::IDX_W'(n);
        end else if (head_eq) begin
          res_index_next = oat_pkg::IDX_W'(ptr);
          res_found_next = 1'b1;
        end else begin
          ctrl.ring_op = oat_pkg::RO_LEFT;
          ptr_next     = ptr + ONE_C;
        end
      end
      oat_pkg::S_SWAP: begin
        if (swap_done) begin
          ctrl.entry_op  = oat_pkg::EO_WRITE;
          ctrl.data      = head;
          n_next         = n - ONE_C;
          res_count_next = oat_pkg::CNT_W'(n - ONE_C);
        end else begin
          ctrl.ring_op = oat_pkg::RO_LEFT;
          ptr_next     = ptr + ONE_C;
        end
      end
      oat_pkg::S_BSEARCH: begin
        if (bs_empty) begin
          res_index_next = exact ? oat_pkg::IDX_W'(n) : oat_pkg::IDX_W'(lo);
          res_found_next = !exact && (lo < n);
        end else if (at_mid) begin
          if (head_lt) begin
            lo_next = mid + ONE_C;
          end else if (head_eq && exact) begin
            res_index_next = oat_pkg::IDX_W'(mid);
            res_found_next = 1'b1;
          end else begin
            hx_next = mid;
          end
        end else if (mid > ptr) begin
          ctrl.ring_op = oat_pkg::RO_LEFT;
          ptr_next     = ptr + ONE_C;
        end else begin
          ctrl.ring_op = oat_pkg::RO_RIGHT;
          ptr_next     = ptr - ONE_C;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= oat_pkg::S_IDLE;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      n     <= n_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    lo         <= lo_next;
    hx         <= hx_next;
    res_index  <= res_index_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
    res_count  <= res_count_next;
    if (accept) begin
      op_q  <= op_in;
      pos_q <= req.position;
      key_q <= req.value;
    end
    if (out_load) begin
      out_index  <= res_index;
      out_found  <= res_found;
      out_status <= res_status;
      out_count  <= res_count;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.index       = out_index;
  assign rsp.found       = out_found;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_count;

endmodule

@@ rtl/ordered_array_table.sv @@
// ----------------------------------------------------------------------------
// ordered_array_table
// Table of up to DEPTH signed 32-bit entries with insert, two kinds of
// delete, linear search, exact binary search and lower-bound search.
// ----------------------------------------------------------------------------
// One request at a time. Insert and ordered delete change the table as the
// request is accepted, all affected cells moving against their neighbours
// together; the result goes through the result register to the response
// register. Searches and swap-last delete copy the table into a readout
// ring (one stage per cell) and rotate it past cell 0, where the sequencer
// reads it; the rotation sets their length. Linear search rotates until a
// match or the end of the entries; swap-last until the last entry reaches
// cell 0, which it writes over the deleted one. Binary searches move the
// ring one place a cycle to each midpoint. A new request is taken once the
// previous result sits in the response register, even if it has not been
// collected. Entries above the count hold whatever was there; no clearing
// pass after reset, only the count is cleared.
// ----------------------------------------------------------------------------
module ordered_array_table #(
  parameter int DEPTH = oat_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  oat_req_if.sink   req,
  oat_rsp_if.source rsp
);

  oat_pkg::cell_ctrl_t ctrl;

  // stored entries and readout ring, one of each per cell
  logic signed [oat_pkg::VAL_W-1:0] entry [DEPTH];
  logic signed [oat_pkg::VAL_W-1:0] ring  [DEPTH];

  // sequencer: decode, ring walk, binary-search bounds, response register
  oat_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .head (ring[0]),
    .ctrl (ctrl)
  );

  // row of cells; ends of the entry chain feed back on themselves,
  // the ring wraps around
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [oat_pkg::VAL_W-1:0] left_entry;
    logic signed [oat_pkg::VAL_W-1:0] right_entry;

    if (g == 0) begin : g_first
      assign left_entry = entry[g];
    end else begin : g_inner_l
      assign left_entry = entry[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_entry = entry[g];
    end else begin : g_inner_r
      assign right_entry = entry[g+1];
    end

    oat_cell #(
      .IDX (g)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ring_left   (ring[(g + DEPTH - 1) % DEPTH]),
      .ring_right  (ring[(g + 1) % DEPTH]),
      .entry       (entry[g]),
      .ring        (ring[g])
    );
  end

endmodule

@@ rtl/oat_checker.sv @@
// ----------------------------------------------------------------------------
// oat_checker
// Port-level checks for the ordered array table, bound to the top level.
// ----------------------------------------------------------------------------
module oat_checker #(
  parameter int DEPTH = oat_pkg::DEPTH_DEFAULT
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [oat_pkg::IDX_W-1:0]    rsp_index,
  input logic                         rsp_found,
  input logic [oat_pkg::STAT_W-1:0]   rsp_status,
  input logic [oat_pkg::CNT_W-1:0]    rsp_count
);

  localparam bit         SMALL    = (DEPTH <= 511);
  localparam logic [9:0] DEPTH_10 = SMALL ? 10'(DEPTH) : 10'd0;

  // one request in flight: no transaction in the cycle after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous still in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable({rsp_index, rsp_found, rsp_status, rsp_count}))
    else $error("stalled response changed");

  a_error_not_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != oat_pkg::STAT_OK) |-> !rsp_found)
    else $error("failed request reports a hit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !SMALL || ({1'b0, rsp_count} <= DEPTH_10))
    else $error("entry count above table depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == oat_pkg::STAT_FULL) |->
      !SMALL || (rsp_count == DEPTH_10[8:0]))
    else $error("table-full status with spare room");

endmodule

bind ordered_array_table oat_checker #(
  .DEPTH (DEPTH)
) u_oat_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_index  (rsp.index),
  .rsp_found  (rsp.found),
  .rsp_status (rsp.status),
  .rsp_count  (rsp.entry_count)
);
